/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sphere mesh block
// Shared helpers that wrap concurrent assertions on the clock.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define ASSERT_ON(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("assertion failed");

`endif

/* src/uvs_pkg.sv */
// ----------------------------------------------------------------------------
// uvs_pkg
// Types and constants shared by the sphere mesh generator modules.
// ----------------------------------------------------------------------------
package uvs_pkg;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_RADIUS       = 3'd0,
      REG_WIDTH_SEG    = 3'd1,
      REG_HEIGHT_SEG   = 3'd2,
      REG_PHI_START    = 3'd3,
      REG_PHI_LENGTH   = 3'd4,
      REG_THETA_START  = 3'd5,
      REG_THETA_LENGTH = 3'd6
   } reg_index_type;

   localparam logic KIND_VERTEX   = 1'b0;
   localparam logic KIND_TRIANGLE = 1'b1;

   localparam int MIN_WIDTH_SEG  = 3;
   localparam int MIN_HEIGHT_SEG = 2;

   localparam logic [16:0] FULL_TURN = 17'd65536;
   localparam logic [16:0] HALF_TURN = 17'd32768;
   localparam logic [15:0] QUARTER_TURN = 16'd16384;

   // Quotient of the angle divide never exceeds a full turn.
   localparam int QUO_W      = 17;
   localparam int DIV_STEP   = 4;
   localparam int DIV_STAGES = (QUO_W + DIV_STEP - 1) / DIV_STEP;

   // Sine pipeline: prepare, square, four Horner steps, final product.
   localparam int TRIG_STAGES = 7;

   // Odd sine polynomial coefficients in Q30, c1 first.
   localparam logic [31:0] SIN_COEF [5] = '{
      32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026995, 32'd172272
   };

   // Per-request data that rides alongside the arithmetic.
   typedef struct packed {
      logic        kind;
      logic [15:0] idx_b;
      logic [15:0] idx_c;
      logic        top;
      logic        bot;
   } side_type;

endpackage

/* src/uvs_div.sv */
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider by a segment count, a few quotient bits per stage.
// ----------------------------------------------------------------------------
module uvs_div #(
   parameter int SEG_W = 8
) (
   input  logic                          clock,
   input  logic [SEG_W+uvs_pkg::QUO_W-1:0] num,
   input  logic [SEG_W-1:0]              den,
   input  logic [uvs_pkg::DIV_STAGES-1:0] en,
   output logic [uvs_pkg::QUO_W-1:0]     quo
);

   localparam int QW = uvs_pkg::QUO_W;
   localparam int NS = uvs_pkg::DIV_STAGES;
   localparam int ST = uvs_pkg::DIV_STEP;

   logic [SEG_W-1:0] rem_ff [NS];
   logic [QW-1:0]    lo_ff  [NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic [SEG_W-1:0] rem_in;
      logic [QW-1:0]    lo_in;

      always_comb begin
         logic [SEG_W:0] t;
         logic           ge;
         if (k == 0) begin
            rem_in = num[SEG_W+QW-1:QW];
            lo_in  = num[QW-1:0];
         end else begin
            rem_in = rem_ff[(k == 0) ? 0 : k-1];
            lo_in  = lo_ff[(k == 0) ? 0 : k-1];
         end
         for (int j = 0; j < ST; j++) begin
            if (k * ST + j < QW) begin
               t      = {rem_in, lo_in[QW-1]};
               ge     = (t >= {1'b0, den});
               lo_in  = {lo_in[QW-2:0], ge};
               rem_in = ge ? SEG_W'(t - {1'b0, den}) : t[SEG_W-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k] <= rem_in;
            lo_ff[k]  <= lo_in;
         end
      end
   end

   assign quo = lo_ff[NS-1];

endmodule

/* src/uvs_trig.sv */
// ----------------------------------------------------------------------------
// uvs_trig
// Pipelined Q1.15 sine of a 16-bit angle by an odd polynomial, as magnitude and sign.
// ----------------------------------------------------------------------------
module uvs_trig #(
   parameter int TRIG_BITS = 16
) (
   input  logic                              clock,
   input  logic [15:0]                       ang,
   input  logic [uvs_pkg::TRIG_STAGES-1:0]   en,
   output logic [14:0]                       mag,
   output logic                              neg
);

   localparam int QB = TRIG_BITS - 2;

   logic [31:0]          a_wide;
   logic [TRIG_BITS-1:0] a;
   logic [QB:0]          rm;
   logic [30:0]          z_in;

   logic [30:0] z_ff  [6];
   logic        hq_ff [6];
   logic [30:0] z2_ff [1:4];
   logic [31:0] p_ff  [2:5];
   logic [14:0] mag_ff;
   logic        neg_ff;

   if (TRIG_BITS >= 16) begin : g_up
      assign a_wide = {16'd0, ang} << (TRIG_BITS - 16);
   end else begin : g_dn
      assign a_wide = ({16'd0, ang} + (32'd1 << (15 - TRIG_BITS))) >> (16 - TRIG_BITS);
   end

   assign a    = a_wide[TRIG_BITS-1:0];
   // Odd quadrants mirror the remainder so the polynomial only sees a rising quarter.
   assign rm   = a[QB] ? (((QB+1)'(1) << QB) - {1'b0, a[QB-1:0]}) : {1'b0, a[QB-1:0]};
   assign z_in = 31'(rm) << (30 - QB);

   logic [61:0] zz;
   assign zz = z_ff[0] * z_ff[0];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         z_ff[0]  <= z_in;
         hq_ff[0] <= a[TRIG_BITS-1];
      end
      if (en[1]) begin
         z_ff[1]  <= z_ff[0];
         hq_ff[1] <= hq_ff[0];
         z2_ff[1] <= zz[60:30];
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_horner
      logic [31:0] p_src;
      logic [62:0] prod;
      if (i == 0) begin : g_first
         assign p_src = uvs_pkg::SIN_COEF[4];
      end else begin : g_next
         assign p_src = p_ff[i+1];
      end
      assign prod = p_src * z2_ff[i+1];

      always_ff @(posedge clock) begin
         if (en[i+2]) begin
            p_ff[i+2]  <= uvs_pkg::SIN_COEF[3-i] - prod[61:30];
            z_ff[i+2]  <= z_ff[i+1];
            hq_ff[i+2] <= hq_ff[i+1];
         end
      end

      // The squared angle is only needed up to the last Horner step.
      if (i < 3) begin : g_z2
         always_ff @(posedge clock) begin
            if (en[i+2]) begin
               z2_ff[i+2] <= z2_ff[i+1];
            end
         end
      end
   end

   logic [62:0] sp;
   logic [33:0] s_rnd;
   logic [18:0] s_q15;
   logic [14:0] s_sat;

   assign sp    = p_ff[5] * z_ff[5];
   assign s_rnd = {1'b0, sp[62:30]} + 34'd16384;
   assign s_q15 = s_rnd[33:15];
   assign s_sat = (s_q15 > 19'd32767) ? 15'd32767 : s_q15[14:0];

   always_ff @(posedge clock) begin
      if (en[6]) begin
         mag_ff <= s_sat;
         neg_ff <= hq_ff[5] && (s_sat != 15'd0);
      end
   end

   assign mag = mag_ff;
   assign neg = neg_ff;

endmodule

/* src/uv_sphere_mesh_generator_unit.sv */
// ----------------------------------------------------------------------------
// uv_sphere_mesh_generator_unit
// UV sphere vertex and triangle generator with a fully pipelined datapath.
// ----------------------------------------------------------------------------
// Requests enter on the req_ stream: tuser selects a vertex (0) or a cell (1),
// and tdata carries the grid row and column. Results leave on the rsp_ stream:
// tuser is the result kind, tlast marks the final beat of a request, and tdata
// carries the position and the three corner indexes.
// A vertex request gives one beat; a cell request gives one or two triangle
// beats. A request outside the grid is dropped at entry and gives no beat.
// The pipeline holds fifteen register stages: the input stage, five stages
// of the angle divider, seven stages of the sine polynomial and two stages of
// radius products. One request is taken every cycle unless a stalled receiver
// holds the pipeline back; a cell request with two triangles holds the output
// register for two beats, which can also hold back intake. Each stage moves
// only when it is empty or its successor moves, so bubbles close up and new
// requests are still taken while a result waits on a stalled receiver. Reset
// clears all valid bits and loads the default sphere (radius one, 32 by 16
// segments, full sweep). The sphere registers must be written through csr_
// only while no request is in flight; the block itself does not enforce
// this.
module uv_sphere_mesh_generator_unit #(
   parameter int MAX_SEGMENTS = 255,
   parameter int TRIG_BITS    = 16
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // row [7:0], col [15:8]
   input  logic         req_tuser,   // req_type
   // Result channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // pos_x [16:0], pos_y [33:17], pos_z [50:34],
                                     // corner_one [66:51], corner_two [82:67],
                                     // corner_three [98:83], zero fill above
   output logic         rsp_tuser,   // kind
   output logic         rsp_tlast,   // last
   // Configuration write port.
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [16:0]  csr_wdata
);

   localparam int SEG_W  = $clog2(MAX_SEGMENTS + 1);
   localparam int NUM_W  = SEG_W + uvs_pkg::QUO_W;
   localparam int DS     = uvs_pkg::DIV_STAGES;
   localparam int TS     = uvs_pkg::TRIG_STAGES;
   localparam int NST    = 1 + DS + TS + 2;
   localparam int TRIG0  = 1 + DS;
   localparam int P1     = TRIG0 + TS;
   localparam int W_RST  = (MAX_SEGMENTS < 32) ? MAX_SEGMENTS : 32;
   localparam int H_RST  = (MAX_SEGMENTS < 16) ? MAX_SEGMENTS : 16;

   // ---------------------------------------------------------------------
   // Sphere registers. Segment writes are clamped, phi length and theta writes saturated.
   // ---------------------------------------------------------------------
   logic [15:0]      radius_ff;
   logic [SEG_W-1:0] wseg_ff, hseg_ff;
   logic [15:0]      phi_start_ff;
   logic [16:0]      phi_len_ff;
   logic [15:0]      th_start_ff, th_len_ff;

   logic [7:0]       seg_wr;
   logic [SEG_W-1:0] wseg_in, hseg_in;
   logic [16:0]      half_sat;

   assign seg_wr   = csr_wdata[7:0];
   assign half_sat = ({1'b0, csr_wdata[15:0]} > uvs_pkg::HALF_TURN) ?
                     uvs_pkg::HALF_TURN : {1'b0, csr_wdata[15:0]};

   always_comb begin
      if (seg_wr < 8'(uvs_pkg::MIN_WIDTH_SEG)) begin
         wseg_in = SEG_W'(uvs_pkg::MIN_WIDTH_SEG);
      end else if (32'(seg_wr) > MAX_SEGMENTS) begin
         wseg_in = SEG_W'(MAX_SEGMENTS);
      end else begin
         wseg_in = SEG_W'(seg_wr);
      end
      if (seg_wr < 8'(uvs_pkg::MIN_HEIGHT_SEG)) begin
         hseg_in = SEG_W'(uvs_pkg::MIN_HEIGHT_SEG);
      end else if (32'(seg_wr) > MAX_SEGMENTS) begin
         hseg_in = SEG_W'(MAX_SEGMENTS);
      end else begin
         hseg_in = SEG_W'(seg_wr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= 16'd256;
         wseg_ff      <= SEG_W'(W_RST);
         hseg_ff      <= SEG_W'(H_RST);
         phi_start_ff <= 16'd0;
         phi_len_ff   <= uvs_pkg::FULL_TURN;
         th_start_ff  <= 16'd0;
         th_len_ff    <= uvs_pkg::HALF_TURN[15:0];
      end else if (csr_we) begin
         case (csr_addr)
            uvs_pkg::REG_RADIUS:       radius_ff    <= csr_wdata[15:0];
            uvs_pkg::REG_WIDTH_SEG:    wseg_ff      <= wseg_in;
            uvs_pkg::REG_HEIGHT_SEG:   hseg_ff      <= hseg_in;
            uvs_pkg::REG_PHI_START:    phi_start_ff <= csr_wdata[15:0];
            uvs_pkg::REG_PHI_LENGTH: begin
               phi_len_ff <= (csr_wdata > uvs_pkg::FULL_TURN) ? uvs_pkg::FULL_TURN : csr_wdata;
            end
            uvs_pkg::REG_THETA_START:  th_start_ff  <= half_sat[15:0];
            uvs_pkg::REG_THETA_LENGTH: th_len_ff    <= half_sat[15:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Stage flow control. A stage loads when it is empty or its successor
   // loads; the last enable comes from the output register.
   // ---------------------------------------------------------------------
   logic [NST-1:0] v_ff;
   logic [NST:0]   en;
   logic           out_free;

   assign en[NST] = out_free;
   for (genvar k = 0; k < NST; k++) begin : g_en
      assign en[k] = !v_ff[k] || en[k+1];
   end

   assign req_tready = en[0];

   // ---------------------------------------------------------------------
   // Input stage: range check, divide numerators and grid indexes.
   // ---------------------------------------------------------------------
   logic [7:0]       row, col;
   logic             is_cell, in_range;
   logic [SEG_W:0]   rw;
   logic [24:0]      phi_prod;
   logic [23:0]      th_prod;
   logic [16:0]      th_end;
   uvs_pkg::side_type side_in;

   assign row     = req_tdata[7:0];
   assign col     = req_tdata[15:8];
   assign is_cell = (req_tuser == uvs_pkg::KIND_TRIANGLE);
   assign rw      = {1'b0, wseg_ff} + (SEG_W+1)'(1);
   assign th_end  = {1'b0, th_start_ff} + {1'b0, th_len_ff};

   always_comb begin
      if (is_cell) begin
         in_range = (32'(row) < 32'(hseg_ff)) && (32'(col) < 32'(wseg_ff));
      end else begin
         in_range = (32'(row) <= 32'(hseg_ff)) && (32'(col) <= 32'(wseg_ff));
      end
      side_in.kind  = req_tuser;
      side_in.idx_b = 16'(row * rw + 32'(col));
      side_in.idx_c = 16'(side_in.idx_b + 16'(rw));
      side_in.top   = (row != 8'd0) || (th_start_ff != 16'd0);
      side_in.bot   = (32'(row) != 32'(hseg_ff) - 32'd1) || (th_end < uvs_pkg::HALF_TURN);
   end

   assign phi_prod = col * phi_len_ff;
   assign th_prod  = row * th_len_ff;

   logic [NUM_W-1:0]  num_phi_ff, num_th_ff;
   uvs_pkg::side_type side_ff [NST];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         // Adding half the divisor rounds the quotient to nearest.
         num_phi_ff <= NUM_W'(phi_prod + 25'(wseg_ff >> 1));
         num_th_ff  <= NUM_W'(th_prod + 24'(hseg_ff >> 1));
         side_ff[0] <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
               v_ff[k] <= (k == 0) ? (req_tvalid && in_range) : v_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   end

   for (genvar k = 1; k < NST; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (en[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Angle divide, then sine and cosine of both angles.
   // ---------------------------------------------------------------------
   logic [uvs_pkg::QUO_W-1:0] quo_phi, quo_th;
   logic [15:0] phi, theta, phi_c, theta_c;

   uvs_div #(.SEG_W(SEG_W)) u_div_phi (
      .clock (clock), .num (num_phi_ff), .den (wseg_ff), .en (en[DS:1]), .quo (quo_phi)
   );
   uvs_div #(.SEG_W(SEG_W)) u_div_theta (
      .clock (clock), .num (num_th_ff), .den (hseg_ff), .en (en[DS:1]), .quo (quo_th)
   );

   assign phi     = phi_start_ff + quo_phi[15:0];
   assign theta   = th_start_ff + quo_th[15:0];
   assign phi_c   = phi + uvs_pkg::QUARTER_TURN;
   assign theta_c = theta + uvs_pkg::QUARTER_TURN;

   logic [14:0] sp, cp, st, ct;
   logic        nsp, ncp, nst, nct;

   uvs_trig #(.TRIG_BITS(TRIG_BITS)) u_sin_phi (
      .clock (clock), .ang (phi), .en (en[P1-1:TRIG0]), .mag (sp), .neg (nsp)
   );
   uvs_trig #(.TRIG_BITS(TRIG_BITS)) u_cos_phi (
      .clock (clock), .ang (phi_c), .en (en[P1-1:TRIG0]), .mag (cp), .neg (ncp)
   );
   uvs_trig #(.TRIG_BITS(TRIG_BITS)) u_sin_theta (
      .clock (clock), .ang (theta), .en (en[P1-1:TRIG0]), .mag (st), .neg (nst)
   );
   uvs_trig #(.TRIG_BITS(TRIG_BITS)) u_cos_theta (
      .clock (clock), .ang (theta_c), .en (en[P1-1:TRIG0]), .mag (ct), .neg (nct)
   );

   // ---------------------------------------------------------------------
   // Radius products on magnitudes, rounded to Q8.8, then signed.
   // ---------------------------------------------------------------------
   logic [30:0] rc_ff, rs_ff;
   logic [14:0] st_ff;
   logic [16:0] my_ff;
   logic        xneg_ff, yneg_ff, zneg_ff;
   logic [31:0] ry;

   assign ry = (radius_ff * ct) + 32'd16384;

   always_ff @(posedge clock) begin
      if (en[P1]) begin
         rc_ff   <= radius_ff * cp;
         rs_ff   <= radius_ff * sp;
         st_ff   <= st;
         my_ff   <= ry[31:15];
         xneg_ff <= (ncp == nst);
         yneg_ff <= nct;
         zneg_ff <= (nsp != nst);
      end
   end

   logic [46:0] mx, mz;
   logic [16:0] px_ff, py_ff, pz_ff;

   assign mx = (rc_ff * st_ff) + 47'(1 << 29);
   assign mz = (rs_ff * st_ff) + 47'(1 << 29);

   always_ff @(posedge clock) begin
      if (en[P1+1]) begin
         px_ff <= xneg_ff ? (17'd0 - mx[46:30]) : mx[46:30];
         py_ff <= yneg_ff ? (17'd0 - my_ff) : my_ff;
         pz_ff <= zneg_ff ? (17'd0 - mz[46:30]) : mz[46:30];
      end
   end

   // ---------------------------------------------------------------------
   // Output register. A cell with both triangles stays for a second beat.
   // ---------------------------------------------------------------------
   logic        rsp_valid_ff, second_ff, rsp_user_ff, rsp_last_ff;
   logic [16:0] ox_ff, oy_ff, oz_ff;
   logic [15:0] c1_ff, c2_ff, c3_ff, hold_b_ff, hold_c_ff;
   uvs_pkg::side_type so;

   assign so       = side_ff[NST-1];
   assign out_free = !rsp_valid_ff || (rsp_tready && !second_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else if (out_free) begin
         second_ff <= 1'b0;
         if (!v_ff[NST-1]) begin
            rsp_valid_ff <= 1'b0;
         end else if (so.kind == uvs_pkg::KIND_VERTEX) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            rsp_valid_ff <= so.top || so.bot;
            second_ff    <= so.top && so.bot;
         end
      end else if (rsp_tready) begin
         second_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_user_ff <= so.kind;
         hold_b_ff   <= so.idx_b;
         hold_c_ff   <= so.idx_c;
         if (so.kind == uvs_pkg::KIND_VERTEX) begin
            ox_ff       <= px_ff;
            oy_ff       <= py_ff;
            oz_ff       <= pz_ff;
            c1_ff       <= so.idx_b;
            c2_ff       <= 16'd0;
            c3_ff       <= 16'd0;
            rsp_last_ff <= 1'b1;
         end else begin
            ox_ff <= 17'd0;
            oy_ff <= 17'd0;
            oz_ff <= 17'd0;
            if (so.top) begin
               c1_ff       <= so.idx_b + 16'd1;
               c2_ff       <= so.idx_b;
               c3_ff       <= so.idx_c + 16'd1;
               rsp_last_ff <= !so.bot;
            end else begin
               c1_ff       <= so.idx_b;
               c2_ff       <= so.idx_c;
               c3_ff       <= so.idx_c + 16'd1;
               rsp_last_ff <= 1'b1;
            end
         end
      end else if (rsp_tready && second_ff) begin
         // Bottom triangle of the cell that was just delivered.
         c1_ff       <= hold_b_ff;
         c2_ff       <= hold_c_ff;
         c3_ff       <= hold_c_ff + 16'd1;
         rsp_last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'd0, c3_ff, c2_ff, c1_ff, oz_ff, oy_ff, ox_ff};

endmodule

/* src/uvs_checker.sv */
// ----------------------------------------------------------------------------
// uvs_checker
// Port-level checks on the result stream of the sphere mesh generator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uvs_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata,
   input logic         rsp_tuser,
   input logic         rsp_tlast
);

   // A stalled beat stays offered.
   `ASSERT_ON(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   // A vertex is always the only beat of its request.
   `ASSERT_ON(a_vertex_last, rsp_tvalid && !rsp_tuser |-> rsp_tlast)
   // Vertices carry no second or third corner.
   `ASSERT_ON(a_vertex_corners, rsp_tvalid && !rsp_tuser |-> rsp_tdata[98:67] == 32'd0)
   // Triangles carry no position.
   `ASSERT_ON(a_tri_pos, rsp_tvalid && rsp_tuser |-> rsp_tdata[50:0] == 51'd0)
   // Nothing is offered in the cycle after a reset edge.
   `ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid)

endmodule

bind uv_sphere_mesh_generator_unit uvs_checker u_uvs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UV sphere mesh generator.
// ----------------------------------------------------------------------------
// Requests are sent with random gaps while the result side stalls at random.
// Every accepted request is run through a local model of the sphere, and the
// beats it should produce are queued. Each result beat is compared field by
// field with the oldest queued beat. The sphere registers are rewritten only
// when the pipeline has drained, and the run steps through default, extreme
// and random sphere settings.
// ----------------------------------------------------------------------------
module tb_top;

   // Latency from request to result, plus margin for the drain checks.
   localparam int PIPE_LAT     = 15;
   localparam int DRAIN_CYCLES = PIPE_LAT + 8;
   localparam int MAX_SEG      = 255;
   localparam int MAX_REPORTS  = 10;
   // The write port has room for one index that maps to no register.
   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam logic REQ_VERTEX = 1'b0;
   localparam logic REQ_CELL   = 1'b1;

   // One result beat as the block should deliver it.
   typedef struct packed {
      logic        kind;
      logic [16:0] pos_x;
      logic [16:0] pos_y;
      logic [16:0] pos_z;
      logic [15:0] corner_one;
      logic [15:0] corner_two;
      logic [15:0] corner_three;
      logic        last;
   } mesh_beat_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [15:0]  req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_addr = '0;
   logic [16:0]  csr_wdata = '0;

   // Local copy of the sphere registers, updated as the block's are.
   logic [15:0] sph_radius;
   logic [7:0]  sph_wseg;
   logic [7:0]  sph_hseg;
   logic [15:0] sph_phi_start;
   logic [16:0] sph_phi_len;
   logic [15:0] sph_theta_start;
   logic [15:0] sph_theta_len;

   mesh_beat_type pending_beats[$];
   int error_count = 0;
   int report_count = 0;
   // When set, neither side idles, so back-to-back traffic is exercised.
   bit no_idle = 1'b0;
   int stall_left = 0;

   uv_sphere_mesh_generator_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard limit on the run, far beyond the slowest legal completion.
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int idle_cycles();
      int pick;
      begin
         pick = $urandom_range(99);
         if (no_idle || pick < 60) return 0;
         if (pick < 95) return $urandom_range(3, 1);
         return $urandom_range(40, 10);
      end
   endfunction

   // Sine of a 16-bit angle in Q1.15, as magnitude and sign. The angle is
   // folded into the first quadrant and fed to an odd polynomial in Q30.
   function automatic logic [15:0] sine_q15(input logic [15:0] ang, output bit neg);
      logic [1:0] quad;
      longint unsigned rem, z, z2, p, s;
      begin
         quad = ang[15:14];
         rem = 64'(ang[13:0]);
         if (quad[0]) rem = 16384 - rem;
         z = rem << 16;
         z2 = (z * z) >> 30;
         p = 64'(uvs_pkg::SIN_COEF[4]);
         for (int i = 3; i >= 0; i--) p = 64'(uvs_pkg::SIN_COEF[i]) - ((p * z2) >> 30);
         s = (p * z) >> 30;
         s = (s + (1 << 14)) >> 15;
         if (s > 32767) s = 32767;
         neg = quad[1] && (s != 0);
         return s[15:0];
      end
   endfunction

   function automatic logic [16:0] apply_sign(input longint unsigned mag, input bit neg);
      begin
         return neg ? 17'(-mag) : 17'(mag);
      end
   endfunction

   // Works out the beats that one request causes and queues them.
   task automatic predict_mesh_beats(input logic kind, input logic [7:0] row,
                                     input logic [7:0] col);
      longint unsigned w, h, rw, phi_q, theta_q, mx, my, mz;
      logic [15:0] phi, theta, sp, cp, st, ct;
      logic [15:0] ia, ib, ic, id;
      bit nsp, ncp, nst, nct, top, bot;
      mesh_beat_type beat;
      begin
         w = 64'(sph_wseg);
         h = 64'(sph_hseg);
         rw = w + 1;
         beat = '0;
         if (kind == REQ_VERTEX) begin
            // Grid points run from 0 to the segment count inclusive.
            if (row > h || col > w) return;
            phi_q = (col * longint'(sph_phi_len) + w / 2) / w;
            theta_q = (row * longint'(sph_theta_len) + h / 2) / h;
            phi = 16'(sph_phi_start + phi_q);
            theta = 16'(sph_theta_start + theta_q);
            sp = sine_q15(phi, nsp);
            cp = sine_q15(phi + uvs_pkg::QUARTER_TURN, ncp);
            st = sine_q15(theta, nst);
            ct = sine_q15(theta + uvs_pkg::QUARTER_TURN, nct);
            mx = (longint'(sph_radius) * cp * st + (longint'(1) << 29)) >> 30;
            my = (longint'(sph_radius) * ct + (1 << 14)) >> 15;
            mz = (longint'(sph_radius) * sp * st + (longint'(1) << 29)) >> 30;
            beat.kind = uvs_pkg::KIND_VERTEX;
            beat.pos_x = apply_sign(mx, ncp == nst);
            beat.pos_y = apply_sign(my, nct);
            beat.pos_z = apply_sign(mz, nsp != nst);
            beat.corner_one = 16'(row * rw + col);
            beat.last = 1'b1;
            pending_beats = {pending_beats, beat};
         end else begin
            if (row >= h || col >= w) return;
            ib = 16'(row * rw + col);
            ia = ib + 16'd1;
            ic = 16'((row + 1) * rw + col);
            id = ic + 16'd1;
            // The pole triangle vanishes when the sweep starts at the pole,
            // and the bottom one when it reaches the opposite pole.
            top = (row != 0) || (sph_theta_start > 0);
            bot = (row != h - 1) ||
                  (32'(sph_theta_start) + 32'(sph_theta_len) < 32'(uvs_pkg::HALF_TURN));
            beat.kind = uvs_pkg::KIND_TRIANGLE;
            if (top) begin
               beat.corner_one = ia;
               beat.corner_two = ib;
               beat.corner_three = id;
               beat.last = !bot;
               pending_beats = {pending_beats, beat};
            end
            if (bot) begin
               beat.corner_one = ib;
               beat.corner_two = ic;
               beat.corner_three = id;
               beat.last = 1'b1;
               pending_beats = {pending_beats, beat};
            end
         end
      end
   endtask

   // Sends one request beat after a random gap and predicts its results at
   // the accepting edge. Valid stays high when the next beat follows at once.
   task automatic send_request(input logic kind, input logic [7:0] row,
                               input logic [7:0] col);
      int gap;
      begin
         gap = idle_cycles();
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tuser <= kind;
         req_tdata <= {col, row};
         do @(posedge clock); while (!req_tready);
         predict_mesh_beats(kind, row, col);
      end
   endtask

   // Lets every queued beat arrive, then lets dropped requests clear the pipe.
   task automatic wait_idle();
      begin
         req_tvalid <= 1'b0;
         while (pending_beats.size() != 0) @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
      end
   endtask

   function automatic logic [7:0] clamp_segments(input logic [7:0] v, input int lo);
      begin
         if (v < lo) return 8'(lo);
         if (v > MAX_SEG) return 8'(MAX_SEG);
         return v;
      end
   endfunction

   // Writes one register on an idle block and mirrors the write locally.
   task automatic write_reg(input logic [2:0] index, input logic [16:0] value);
      begin
         wait_idle();
         csr_we <= 1'b1;
         csr_addr <= index;
         csr_wdata <= value;
         @(posedge clock);
         csr_we <= 1'b0;
         case (index)
            uvs_pkg::REG_RADIUS: sph_radius = value[15:0];
            uvs_pkg::REG_WIDTH_SEG: begin
               sph_wseg = clamp_segments(value[7:0], uvs_pkg::MIN_WIDTH_SEG);
            end
            uvs_pkg::REG_HEIGHT_SEG: begin
               sph_hseg = clamp_segments(value[7:0], uvs_pkg::MIN_HEIGHT_SEG);
            end
            uvs_pkg::REG_PHI_START: sph_phi_start = value[15:0];
            uvs_pkg::REG_PHI_LENGTH: begin
               sph_phi_len = (value > uvs_pkg::FULL_TURN) ? uvs_pkg::FULL_TURN : value;
            end
            uvs_pkg::REG_THETA_START: begin
               sph_theta_start = (value[15:0] > uvs_pkg::HALF_TURN) ?
                                 uvs_pkg::HALF_TURN[15:0] : value[15:0];
            end
            uvs_pkg::REG_THETA_LENGTH: begin
               sph_theta_len = (value[15:0] > uvs_pkg::HALF_TURN) ?
                               uvs_pkg::HALF_TURN[15:0] : value[15:0];
            end
            default: ;
         endcase
      end
   endtask

   task automatic set_sphere(input logic [16:0] rad, input logic [16:0] w,
                             input logic [16:0] h, input logic [16:0] ps,
                             input logic [16:0] pl, input logic [16:0] ts,
                             input logic [16:0] tl);
      begin
         write_reg(uvs_pkg::REG_RADIUS, rad);
         write_reg(uvs_pkg::REG_WIDTH_SEG, w);
         write_reg(uvs_pkg::REG_HEIGHT_SEG, h);
         write_reg(uvs_pkg::REG_PHI_START, ps);
         write_reg(uvs_pkg::REG_PHI_LENGTH, pl);
         write_reg(uvs_pkg::REG_THETA_START, ts);
         write_reg(uvs_pkg::REG_THETA_LENGTH, tl);
      end
   endtask

   // Grid corners, the edge of the grid and just past it, for both kinds.
   task automatic send_grid_edges();
      logic [7:0] w, h;
      begin
         w = sph_wseg;
         h = sph_hseg;
         send_request(REQ_VERTEX, 8'd0, 8'd0);
         send_request(REQ_VERTEX, h, w);
         send_request(REQ_VERTEX, h >> 1, w >> 2);
         send_request(REQ_VERTEX, h + 8'd1, 8'd0);
         send_request(REQ_VERTEX, 8'd0, w + 8'd1);
         send_request(REQ_VERTEX, 8'd255, 8'd255);
         send_request(REQ_CELL, 8'd0, 8'd0);
         send_request(REQ_CELL, h - 8'd1, w - 8'd1);
         send_request(REQ_CELL, h >> 1, w >> 1);
         send_request(REQ_CELL, h, 8'd0);
         send_request(REQ_CELL, 8'd0, w);
         send_request(REQ_CELL, 8'd255, 8'd255);
      end
   endtask

   // Random requests, mostly on the grid, the rest anywhere.
   task automatic send_random(input int count);
      logic kind;
      logic [7:0] row, col;
      begin
         for (int n = 0; n < count; n++) begin
            kind = 1'($urandom_range(1));
            if ($urandom_range(9) != 0) begin
               row = 8'($urandom_range(kind ? sph_hseg - 8'd1 : sph_hseg));
               col = 8'($urandom_range(kind ? sph_wseg - 8'd1 : sph_wseg));
            end else begin
               row = 8'($urandom_range(255));
               col = 8'($urandom_range(255));
            end
            if (n % 64 == 0) no_idle = ($urandom_range(3) == 0);
            send_request(kind, row, col);
         end
         no_idle = 1'b0;
      end
   endtask

   task automatic test_default_sphere();
      begin
         send_grid_edges();
      end
   endtask

   // Clamped and saturated writes, the ignored index, and extreme spheres.
   task automatic test_extreme_spheres();
      begin
         set_sphere(17'h1FFFF, 17'd0, 17'd1, 17'hFFFF, 17'h1FFFF, 17'hFFFF, 17'hFFFF);
         write_reg(REG_UNUSED, 17'h1FFFF);
         send_grid_edges();
         send_random(60);
         set_sphere(17'd0, 17'd255, 17'd255, 17'd0, 17'd0, 17'd0, 17'd0);
         send_grid_edges();
         send_random(60);
         set_sphere(17'd65535, 17'd3, 17'd2, 17'd12345, 17'd65536, 17'd8000, 17'd24768);
         send_grid_edges();
         send_random(60);
      end
   endtask

   task automatic test_random_spheres();
      begin
         for (int phase = 0; phase < 8; phase++) begin
            set_sphere(17'($urandom_range(65535)), 17'($urandom_range(300)),
                       17'($urandom_range(300)), 17'($urandom_range(65535)),
                       17'($urandom_range(131071)), 17'($urandom_range(40000)),
                       17'($urandom_range(40000)));
            // Small grids keep edge cases frequent; some phases use the raw draw.
            if (phase < 4) begin
               write_reg(uvs_pkg::REG_WIDTH_SEG, 17'($urandom_range(12, 3)));
               write_reg(uvs_pkg::REG_HEIGHT_SEG, 17'($urandom_range(8, 2)));
            end
            send_random(100);
         end
      end
   endtask

   // Result side: random stalls, and a check of every accepted beat.
   always @(posedge clock) begin
      mesh_beat_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.pos_x = rsp_tdata[16:0];
            got.pos_y = rsp_tdata[33:17];
            got.pos_z = rsp_tdata[50:34];
            got.corner_one = rsp_tdata[66:51];
            got.corner_two = rsp_tdata[82:67];
            got.corner_three = rsp_tdata[98:83];
            got.last = rsp_tlast;
            if (pending_beats.size() == 0) begin
               error_count++;
               if (report_count < MAX_REPORTS) begin
                  report_count++;
                  $display("unexpected result beat: %p", got);
               end
            end else begin
               want = pending_beats.pop_front();
               if (got.kind !== want.kind || got.pos_x !== want.pos_x ||
                   got.pos_y !== want.pos_y || got.pos_z !== want.pos_z ||
                   got.corner_one !== want.corner_one ||
                   got.corner_two !== want.corner_two ||
                   got.corner_three !== want.corner_three || got.last !== want.last) begin
                  error_count++;
                  if (report_count < MAX_REPORTS) begin
                     report_count++;
                     $display("result mismatch: expected %p actual %p", want, got);
                  end
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            stall_left <= idle_cycles();
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      // Mirror the register values that reset loads.
      sph_radius = 16'd256;
      sph_wseg = 8'd32;
      sph_hseg = 8'd16;
      sph_phi_start = 16'd0;
      sph_phi_len = uvs_pkg::FULL_TURN;
      sph_theta_start = 16'd0;
      sph_theta_len = uvs_pkg::HALF_TURN[15:0];
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_sphere();
      test_extreme_spheres();
      test_random_spheres();
      wait_idle();
      if (error_count == 0 && pending_beats.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
